>>> hw/rtl/lmps_pkg.sv
// shared constants, types and state encoding for the led matrix row scanner
package lmps_pkg;

    // matrix geometry and intensity resolution
    localparam int ROWS         = 8;
    localparam int COLS         = 16;
    localparam int LEVELS       = 64;
    localparam int CHANNEL_BITS = 6;

    // fixed field widths of the channels
    localparam int ROW_IN_W = 3;
    localparam int COL_IN_W = 4;
    localparam int LVL_IN_W = 6;
    localparam int OUT_W    = 16;
    localparam int SROW_W   = 3;

    // derived widths
    localparam int SCAN_COLS = (COLS < OUT_W) ? COLS : OUT_W;
    localparam int DEPTH     = ROWS * COLS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(SCAN_COLS);
    localparam int THR_W     = $clog2(LEVELS);
    localparam int PIX_W     = 2 * CHANNEL_BITS;
    localparam int CMP_W     = (CHANNEL_BITS > THR_W) ? CHANNEL_BITS : THR_W;

    // input function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_SCAN  = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_LOAD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic wr_pixel;
        logic scan_start;
        logic scan_step;
        logic load_out;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last_col;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hw/rtl/lmps_if.sv
// channel interfaces: pixel/tick input and row result output
interface lmps_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [lmps_pkg::ROW_IN_W-1:0] pixel_row;
    logic [lmps_pkg::COL_IN_W-1:0] pixel_col;
    logic [lmps_pkg::LVL_IN_W-1:0] red_level;
    logic [lmps_pkg::LVL_IN_W-1:0] green_level;

    modport source (output valid, func, pixel_row, pixel_col, red_level, green_level,
                    input ready);
    modport sink (input valid, func, pixel_row, pixel_col, red_level, green_level,
                  output ready);
endinterface

interface lmps_res_if;
    logic                        valid;
    logic                        ready;
    logic [lmps_pkg::OUT_W-1:0]  red_bits;
    logic [lmps_pkg::OUT_W-1:0]  green_bits;
    logic [lmps_pkg::SROW_W-1:0] scan_row;
    logic                        first_row;
    logic                        frame_done;

    modport source (output valid, red_bits, green_bits, scan_row, first_row, frame_done,
                    input ready);
    modport sink (input valid, red_bits, green_bits, scan_row, first_row, frame_done,
                  output ready);
endinterface

>>> hw/rtl/led_matrix_pwm_row_scanner.sv
// top level of the two-color led matrix pwm row scanner
//
// i_in carries one transaction per item: func 0 writes one pixel (red and green
// level) into the framebuffer, func 1 is a scan tick for the current row.
// o_res carries one transaction per scan tick: the red and green column bits of
// the row (bit c lit when the level is above the current threshold), the row
// number, a first-row flag and a frame-done flag. Writes give no result.
// A pixel write is accepted and the next item can follow at once.
// A scan tick reads the row one column per cycle through the single read port
// of the framebuffer ram: reads of all SCAN_COLS columns in the read state, a
// drain state for the last read data and a load state that moves the row into
// the output register; the next item is taken after the load, and no item is
// accepted while the row is being read.
// The result waits in an output register; while it waits, further writes and
// a following tick are accepted, and the tick holds its result until the
// receiver has taken the previous one.
// Reset clears the row counter, the threshold and the framebuffer (through
// per-entry valid bits, so no clearing pass is needed) and drops any result.
module led_matrix_pwm_row_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmps_in_if.sink    i_in,
    lmps_res_if.source o_res
);
    lmps_pkg::t_dp_cmd dp_cmd;
    lmps_pkg::t_dp_sts dp_sts;
    logic              in_ready;

    assign i_in.ready = in_ready;

    lmps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    lmps_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_pixel_row   (i_in.pixel_row),
        .i_pixel_col   (i_in.pixel_col),
        .i_red_level   (i_in.red_level),
        .i_green_level (i_in.green_level),
        .o_res         (o_res)
    );

    // a loaded result shows up on the output next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |=> o_res.valid)
        else $error("result not presented after load");

    // a frame ends on the last row, never on the first
    a_done_not_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_done) |-> !o_res.first_row)
        else $error("frame done flagged on first row");

    // framebuffer is never written while a row is being read
    a_no_wr_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dp_cmd.wr_pixel && dp_cmd.scan_step))
        else $error("pixel write during row read");

    // a result is only loaded when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> (!o_res.valid || o_res.ready))
        else $error("result overwritten before taken");
endmodule

>>> hw/rtl/lmps_ram.sv
// generic single write port, single read port ram with registered read
module lmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> hw/rtl/lmps_datapath.sv
// datapath: framebuffer, row and threshold counters, column compare and result register
module lmps_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lmps_pkg::t_dp_cmd             i_cmd,
    output lmps_pkg::t_dp_sts             o_sts,
    input  logic [lmps_pkg::ROW_IN_W-1:0] i_pixel_row,
    input  logic [lmps_pkg::COL_IN_W-1:0] i_pixel_col,
    input  logic [lmps_pkg::LVL_IN_W-1:0] i_red_level,
    input  logic [lmps_pkg::LVL_IN_W-1:0] i_green_level,
    lmps_res_if.source                    o_res
);
    localparam int CB = lmps_pkg::CHANNEL_BITS;

    logic [lmps_pkg::ROW_W-1:0]  r_row;
    logic [lmps_pkg::THR_W-1:0]  r_thr;
    logic [lmps_pkg::COL_W-1:0]  r_col;
    logic [lmps_pkg::COL_W-1:0]  r_cap_col;
    logic                        r_cap;
    logic                        r_rd_ok;
    logic [lmps_pkg::DEPTH-1:0]  r_valid;
    logic [lmps_pkg::OUT_W-1:0]  r_red;
    logic [lmps_pkg::OUT_W-1:0]  r_grn;
    logic                        r_out_valid;
    logic [lmps_pkg::OUT_W-1:0]  r_out_red;
    logic [lmps_pkg::OUT_W-1:0]  r_out_grn;
    logic [lmps_pkg::SROW_W-1:0] r_out_row;
    logic                        r_out_first;
    logic                        r_out_done;

    logic [lmps_pkg::ROW_W-1:0]  n_row;
    logic [lmps_pkg::THR_W-1:0]  n_thr;
    logic                        row_wrap;
    logic                        thr_wrap;
    logic                        wr_in_range;
    logic                        wr_en;
    logic [lmps_pkg::ADDR_W-1:0] wr_addr;
    logic [lmps_pkg::ADDR_W-1:0] rd_addr;
    logic [lmps_pkg::PIX_W-1:0]  wr_data;
    logic [lmps_pkg::PIX_W-1:0]  rd_data;
    logic [lmps_pkg::PIX_W-1:0]  pix;
    logic                        lit_red;
    logic                        lit_grn;

    // pixel write address and data, writes outside the matrix dropped
    assign wr_in_range = (int'(i_pixel_row) < lmps_pkg::ROWS)
                      && (int'(i_pixel_col) < lmps_pkg::COLS);
    assign wr_en   = i_cmd.wr_pixel && wr_in_range;
    assign wr_addr = lmps_pkg::ADDR_W'(int'(i_pixel_row) * lmps_pkg::COLS
                                       + int'(i_pixel_col));
    assign wr_data = {CB'(i_red_level), CB'(i_green_level)};
    assign rd_addr = lmps_pkg::ADDR_W'(int'(r_row) * lmps_pkg::COLS + int'(r_col));

    lmps_ram #(
        .WIDTH (lmps_pkg::PIX_W),
        .DEPTH (lmps_pkg::DEPTH)
    ) u_fb (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.scan_step),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // entry valid bits stand in for clearing the framebuffer at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // column read sequencing, read data returns in the cycle after issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_cap <= 1'b0;
        end else begin
            r_cap <= i_cmd.scan_step;
            if (i_cmd.scan_start) begin
                r_col <= '0;
            end else if (i_cmd.scan_step) begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_cap_col <= r_col;
            r_rd_ok   <= r_valid[rd_addr];
        end
    end

    assign o_sts.last_col = (r_col == lmps_pkg::COL_W'(lmps_pkg::SCAN_COLS - 1));

    // threshold compare of the returning pixel
    assign pix     = r_rd_ok ? rd_data : '0;
    assign lit_red = lmps_pkg::CMP_W'(pix[lmps_pkg::PIX_W-1:CB]) > lmps_pkg::CMP_W'(r_thr);
    assign lit_grn = lmps_pkg::CMP_W'(pix[CB-1:0]) > lmps_pkg::CMP_W'(r_thr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_red <= '0;
            r_grn <= '0;
        end else if (r_cap) begin
            r_red[r_cap_col] <= lit_red;
            r_grn[r_cap_col] <= lit_grn;
        end
    end

    // row and threshold advance
    assign row_wrap = (r_row == lmps_pkg::ROW_W'(lmps_pkg::ROWS - 1));
    assign thr_wrap = (r_thr == lmps_pkg::THR_W'(lmps_pkg::LEVELS - 1));

    always_comb begin
        n_row = r_row;
        n_thr = r_thr;
        if (i_cmd.load_out) begin
            if (row_wrap) begin
                n_row = '0;
                n_thr = thr_wrap ? '0 : r_thr + 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_thr <= '0;
        end else begin
            r_row <= n_row;
            r_thr <= n_thr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_red   <= r_red;
            r_out_grn   <= r_grn;
            r_out_row   <= lmps_pkg::SROW_W'(r_row);
            r_out_first <= (r_row == '0);
            r_out_done  <= row_wrap && thr_wrap;
        end
    end

    assign o_sts.out_free  = !r_out_valid || o_res.ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.red_bits   = r_out_red;
    assign o_res.green_bits = r_out_grn;
    assign o_res.scan_row   = r_out_row;
    assign o_res.first_row  = r_out_first;
    assign o_res.frame_done = r_out_done;
endmodule

>>> hw/rtl/lmps_ctrl.sv
// controller: sequences pixel writes and row scans
module lmps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_func,
    output logic               o_in_ready,
    input  lmps_pkg::t_dp_sts  i_sts,
    output lmps_pkg::t_dp_cmd  o_cmd
);
    lmps_pkg::t_state r_state;
    lmps_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lmps_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_func == lmps_pkg::FUNC_SCAN) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = lmps_pkg::ST_READ;
                    end else begin
                        o_cmd.wr_pixel = 1'b1;
                    end
                end
            end
            lmps_pkg::ST_READ: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.last_col) begin
                    n_state = lmps_pkg::ST_DRAIN;
                end
            end
            lmps_pkg::ST_DRAIN: begin
                n_state = lmps_pkg::ST_LOAD;
            end
            lmps_pkg::ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = lmps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lmps_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
